// ----- rtl/psrl_pkg.sv -----
package psrl_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int FOLD_SHIFT    = 20;

    localparam int ADDR_W  = 32;
    localparam int TS_W    = 64;
    localparam int TALLY_W = 32;
    localparam int LIMIT_W = 16;
    localparam int LEN_W   = 40;
    localparam int MODE_W  = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 40;

    localparam logic [LIMIT_W-1:0] LIMIT_NORMAL_RST   = 16'd200;
    localparam logic [LIMIT_W-1:0] LIMIT_ELEVATED_RST = 16'd80;
    localparam logic [LIMIT_W-1:0] LIMIT_CRITICAL_RST = 16'd30;
    localparam logic [LEN_W-1:0]   WINDOW_LEN_RST     = 40'd1000000000;
    localparam logic [LEN_W-1:0]   BLACKHOLE_LEN_RST  = 40'd30000000000;

    localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THREAT_LEVEL     = 3'd0,
        REG_LIMIT_NORMAL     = 3'd1,
        REG_LIMIT_ELEVATED   = 3'd2,
        REG_LIMIT_CRITICAL   = 3'd3,
        REG_WINDOW_LENGTH    = 3'd4,
        REG_BLACKHOLE_LENGTH = 3'd5
    } t_reg_idx;

    typedef enum logic [MODE_W-1:0] {
        MODE_NORMAL   = 2'd0,
        MODE_ELEVATED = 2'd1,
        MODE_CRITICAL = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic [MODE_W-1:0]  threat_level;
        logic [LIMIT_W-1:0] limit_normal;
        logic [LIMIT_W-1:0] limit_elevated;
        logic [LIMIT_W-1:0] limit_critical;
        logic [LEN_W-1:0]   window_length;
        logic [LEN_W-1:0]   blackhole_length;
    } t_cfg;

    typedef struct packed {
        logic               valid;
        logic [ADDR_W-1:0]  key;
        logic [TS_W-1:0]    window_begin;
        logic [TALLY_W-1:0] packet_tally;
        logic [TS_W-1:0]    block_deadline;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic new_entry;
        logic newly_blackholed;
        logic drop;
    } t_verdict;

    function automatic logic [IDX_W-1:0] slot_of(input logic [ADDR_W-1:0] addr);
        logic [ADDR_W-1:0] f;
        f = (addr ^ (addr >> FOLD_SHIFT)) & ADDR_W'(32'h000F_FFFF);
        return f[IDX_W-1:0];
    endfunction

endpackage

// ----- rtl/psrl_ram.sv -----
module psrl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/psrl_cfg_regs.sv -----
module psrl_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [psrl_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [psrl_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output psrl_pkg::t_cfg                   o_cfg
);
    import psrl_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threat_level     <= MODE_NORMAL;
            r_cfg.limit_normal     <= LIMIT_NORMAL_RST;
            r_cfg.limit_elevated   <= LIMIT_ELEVATED_RST;
            r_cfg.limit_critical   <= LIMIT_CRITICAL_RST;
            r_cfg.window_length    <= WINDOW_LEN_RST;
            r_cfg.blackhole_length <= BLACKHOLE_LEN_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_THREAT_LEVEL:     r_cfg.threat_level     <= i_cfg_data[MODE_W-1:0];
                REG_LIMIT_NORMAL:     r_cfg.limit_normal     <= i_cfg_data[LIMIT_W-1:0];
                REG_LIMIT_ELEVATED:   r_cfg.limit_elevated   <= i_cfg_data[LIMIT_W-1:0];
                REG_LIMIT_CRITICAL:   r_cfg.limit_critical   <= i_cfg_data[LIMIT_W-1:0];
                REG_WINDOW_LENGTH:    r_cfg.window_length    <= i_cfg_data[LEN_W-1:0];
                REG_BLACKHOLE_LENGTH: r_cfg.blackhole_length <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/psrl_update.sv -----
module psrl_update (
    input  logic                          i_clk,
    input  logic                          i_load,
    input  psrl_pkg::t_entry              i_rd_entry,
    input  logic [psrl_pkg::ADDR_W-1:0]   i_addr,
    input  logic [psrl_pkg::TS_W-1:0]     i_ts,
    input  psrl_pkg::t_cfg                i_cfg,
    output psrl_pkg::t_entry              o_wr_entry,
    output psrl_pkg::t_verdict            o_verdict
);
    import psrl_pkg::*;

    t_entry             r_old;
    logic               r_hit;
    logic               r_blocked;
    logic               r_expired;
    logic [TALLY_W-1:0] r_tally_inc;

    logic [TS_W-1:0]    elapsed;
    logic [LIMIT_W-1:0] limit;
    logic               over;
    logic [TS_W-1:0]    deadline_new;

    assign elapsed = i_ts - i_rd_entry.window_begin;

    // Evaluate the entry read back from the table
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_old       <= i_rd_entry;
            r_hit       <= i_rd_entry.valid && (i_rd_entry.key == i_addr);
            r_blocked   <= (i_rd_entry.block_deadline != '0) &&
                           (i_ts < i_rd_entry.block_deadline);
            r_expired   <= elapsed > {{(TS_W-LEN_W){1'b0}}, i_cfg.window_length};
            r_tally_inc <= (i_rd_entry.packet_tally == TALLY_MAX) ?
                           i_rd_entry.packet_tally : i_rd_entry.packet_tally + 1'b1;
        end
    end

    always_comb begin
        case (i_cfg.threat_level)
            MODE_ELEVATED: limit = i_cfg.limit_elevated;
            MODE_CRITICAL: limit = i_cfg.limit_critical;
            default:       limit = i_cfg.limit_normal;
        endcase
    end

    assign over         = r_tally_inc > {{(TALLY_W-LIMIT_W){1'b0}}, limit};
    assign deadline_new = i_ts + {{(TS_W-LEN_W){1'b0}}, i_cfg.blackhole_length};

    always_comb begin
        o_wr_entry = r_old;
        o_verdict  = '0;
        if (!r_hit) begin
            o_wr_entry.valid          = 1'b1;
            o_wr_entry.key            = i_addr;
            o_wr_entry.window_begin   = i_ts;
            o_wr_entry.packet_tally   = TALLY_W'(1);
            o_wr_entry.block_deadline = '0;
            o_verdict.new_entry       = 1'b1;
        end else if (r_blocked) begin
            o_verdict.drop = 1'b1;
        end else if (r_expired) begin
            o_wr_entry.window_begin   = i_ts;
            o_wr_entry.packet_tally   = TALLY_W'(1);
            o_wr_entry.block_deadline = '0;
        end else begin
            o_wr_entry.packet_tally = r_tally_inc;
            if (over) begin
                o_wr_entry.block_deadline  = deadline_new;
                o_verdict.drop             = 1'b1;
                o_verdict.newly_blackholed = 1'b1;
            end
        end
    end

endmodule

// ----- rtl/per_source_rate_limiter_core.sv -----
// Per-source fixed-window rate limiter with automatic blackhole. After reset the
// block sweeps its source table once, one entry per cycle (TABLE_ENTRIES entries,
// 1024 by default), and accepts no packet item until the sweep is done;
// configuration writes are taken at any time but must only change while the block
// is idle. For each packet item the table entry is read when the item is
// accepted, evaluated in the next cycle, and written back together with the
// verdict in the EXEC state once the output register is free. The next item is
// accepted in the cycle after the write-back, so the block takes no new item
// before it is through with the last one, as set by the read-modify-write of
// the single entry memory. The verdict sits in an output register, so a stalled
// result does not block the following item until its own write-back.
module per_source_rate_limiter_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // s_axis_tdata: [31:0] source_address, [95:32] timestamp
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [95:0]                          s_axis_tdata,
    // m_axis_tdata: [0] drop, [1] newly_blackholed, [2] new_entry, [7:3] zero
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [7:0]                           m_axis_tdata,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [psrl_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [psrl_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import psrl_pkg::*;

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_clr_idx;
    logic [ADDR_W-1:0] r_addr;
    logic [TS_W-1:0]   r_ts;
    logic              r_out_valid;
    t_verdict          r_out;

    t_cfg              cfg;
    t_entry            rd_entry;
    t_entry            upd_entry;
    t_verdict          verdict;
    logic              out_free;
    logic              accept;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    t_entry            ram_wdata;
    logic              load;
    logic              commit;

    assign out_free = !r_out_valid || m_axis_tready;
    assign accept   = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: if (r_clr_idx == IDX_W'(TABLE_ENTRIES - 1)) n_state = ST_IDLE;
            ST_IDLE:  if (s_axis_tvalid) n_state = ST_READ;
            ST_READ:  n_state = ST_EXEC;
            ST_EXEC:  if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        load          = 1'b0;
        commit        = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = slot_of(r_addr);
        ram_wdata     = upd_entry;
        case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_idx;
                ram_wdata = '0;
            end
            ST_IDLE:  s_axis_tready = 1'b1;
            ST_READ:  load = 1'b1;
            ST_EXEC: begin
                commit = out_free;
                ram_we = out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the item and the verdict payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_addr <= s_axis_tdata[ADDR_W-1:0];
            r_ts   <= s_axis_tdata[ADDR_W+TS_W-1:ADDR_W];
        end
        if (commit) begin
            r_out <= verdict;
        end
    end

    psrl_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    psrl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (slot_of(s_axis_tdata[ADDR_W-1:0])),
        .o_rdata (rd_entry)
    );

    psrl_update u_update (
        .i_clk      (i_clk),
        .i_load     (load),
        .i_rd_entry (rd_entry),
        .i_addr     (r_addr),
        .i_ts       (r_ts),
        .i_cfg      (cfg),
        .o_wr_entry (upd_entry),
        .o_verdict  (verdict)
    );

    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out.new_entry, r_out.newly_blackholed, r_out.drop};

endmodule
